>>> sv/derivative_stencils_five_point_assert.svh
// Assertion macros shared by the five-point derivative RTL.
`ifndef DERIVATIVE_STENCILS_FIVE_POINT_ASSERT_SVH
`define DERIVATIVE_STENCILS_FIVE_POINT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsfp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsfp: next-cycle check failed");

`endif

>>> sv/dsfp_pkg.sv
// Shared types and constants for the five-point derivative block.
`default_nettype none

package dsfp_pkg;

  localparam int OUT_W       = 32;
  localparam int SCALE_W     = 32;
  localparam int SCALE_FRAC  = 16;
  localparam int ROUND_HALF  = 32768;
  localparam int TAPS        = 5;
  localparam int CFG_INDEX_W = 1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd5461;
  localparam logic [1:0]         FILL_FULL   = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_SCALE  = 1'b0,
    REG_SECOND_SCALE = 1'b1
  } cfg_reg_t;

  // Per-word control carried alongside the datapath.
  typedef struct packed {
    logic valid;
    logic last;
  } dsfp_ctl_t;

endpackage

`default_nettype wire

>>> sv/derivative_stencils_five_point.sv
// Top level of the five-point central-difference derivative block.
`default_nettype none

// Takes one signed sample per clock on the s_ stream, frames marked by s_tlast.
// Each result word carries the scaled first and second derivative for one
// sample position, with zero padding outside the frame. Results lag two
// samples; the frame's last sample releases up to three results, one per
// cycle unless stalled, and input stalls until the last is taken. Otherwise
// one sample is taken every cycle unless the output stalls. Taps pass registers
// for the stencil sum, two partial products by 17-bit scale halves, rounding
// add and saturation to m_tvalid. The whole result pipeline advances when
// the output register is empty or taken. The user must write scales on the cfg
// port only while idle, unenforced by the block; cfg_ready is always high.
module derivative_stencils_five_point
  import dsfp_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,   // sample, zero fill
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [2*OUT_W-1:0]     m_tdata,   // second_deriv (high), first_deriv (low)
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]     cfg_data
);

`include "derivative_stencils_five_point_assert.svh"

  localparam int SUM_W = SAMPLE_BITS + 6;

  logic [SCALE_W-1:0] first_scale;
  logic [SCALE_W-1:0] second_scale;

  dsfp_ctl_t                        job;
  logic [TAPS-1:0][SAMPLE_BITS-1:0] taps;
  logic                             adv;

  logic signed [SUM_W-1:0] ta, tb, tc, td, te;
  logic signed [SUM_W-1:0] sum1_next;
  logic signed [SUM_W-1:0] sum2_next;
  logic signed [SUM_W-1:0] sum1;
  logic signed [SUM_W-1:0] sum2;
  logic signed [OUT_W-1:0] first_deriv;
  logic signed [OUT_W-1:0] second_deriv;

  dsfp_ctl_t st1, st2, st3, st_out;

  assign adv       = !st_out.valid || m_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_scale  <= SCALE_RESET;
      second_scale <= SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIRST_SCALE:  first_scale  <= cfg_data;
        REG_SECOND_SCALE: second_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  dsfp_job_seq #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_job_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sample   (s_tdata[SAMPLE_BITS-1:0]),
    .s_tlast  (s_tlast),
    .take     (adv),
    .job      (job),
    .taps     (taps)
  );

  assign ta = SUM_W'($signed(taps[0]));
  assign tb = SUM_W'($signed(taps[1]));
  assign tc = SUM_W'($signed(taps[2]));
  assign td = SUM_W'($signed(taps[3]));
  assign te = SUM_W'($signed(taps[4]));

  assign sum1_next = ta - (tb <<< 3) + (td <<< 3) - te;
  assign sum2_next = (tb <<< 4) + (td <<< 4) - (tc <<< 5) + (tc <<< 1) - ta - te;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum1 <= sum1_next;
      sum2 <= sum2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1    <= '0;
      st2    <= '0;
      st3    <= '0;
      st_out <= '0;
    end else if (adv) begin
      st1    <= job;
      st2    <= st1;
      st3    <= st2;
      st_out <= st3;
    end
  end

  dsfp_scale #(
    .SUM_W(SUM_W)
  ) u_scale_first (
    .clk    (clk),
    .en     (adv),
    .sum    (sum1),
    .scale  (first_scale),
    .result (first_deriv)
  );

  dsfp_scale #(
    .SUM_W(SUM_W)
  ) u_scale_second (
    .clk    (clk),
    .en     (adv),
    .sum    (sum2),
    .scale  (second_scale),
    .result (second_deriv)
  );

  assign m_tvalid = st_out.valid;
  assign m_tlast  = st_out.last;
  assign m_tdata  = {second_deriv, first_deriv};

  `DSFP_ASSERT_IMPL(a_no_take_while_busy, clk, rst, job.valid && !adv, !s_tready)
  `DSFP_ASSERT_NEXT(a_last_gives_result, clk, rst, s_tvalid && s_tready && s_tlast, job.valid)
  `DSFP_ASSERT_NEXT(a_pipe_holds, clk, rst, st1.valid && !adv, st1.valid)

endmodule

`default_nettype wire

>>> sv/dsfp_job_seq.sv
// Sample window, frame fill tracking and per-result tap sequencing.
`default_nettype none

module dsfp_job_seq
  import dsfp_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic                             s_tlast,
  input  logic                             take,
  output dsfp_ctl_t                        job,
  output logic [TAPS-1:0][SAMPLE_BITS-1:0] taps
);

  logic [1:0]                       fill;
  logic [3:0][SAMPLE_BITS-1:0]      win;
  logic                             item_v;
  logic [2:0]                       mask;
  logic [TAPS-1:0][SAMPLE_BITS-1:0] seq;

  logic [1:0] job_idx;
  logic [2:0] job_bit;
  logic [2:0] remain;
  logic [2:0] new_mask;
  logic       done;
  logic       accept;

  // Lowest pending result first: position n-2, then n-1, then n.
  always_comb begin
    priority if (mask[0]) begin
      job_idx = 2'd0;
      job_bit = 3'b001;
    end else if (mask[1]) begin
      job_idx = 2'd1;
      job_bit = 3'b010;
    end else begin
      job_idx = 2'd2;
      job_bit = 3'b100;
    end
  end

  assign remain   = mask & ~job_bit;
  assign done     = take && item_v && (remain == 3'b000);
  assign s_tready = !item_v || done;
  assign accept   = s_tvalid && s_tready;
  assign new_mask = {s_tlast, s_tlast && (fill != 2'd0), fill == FILL_FULL};

  assign job.valid = item_v;
  assign job.last  = job_bit[2];

  // Taps past the end of the frame are zero.
  always_comb begin
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 0; i < TAPS; i++) begin
      idx = 3'(i) + {1'b0, job_idx};
      taps[i] = (idx < 3'(TAPS)) ? seq[idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
      fill   <= 2'd0;
      win    <= '0;
    end else begin
      if (accept) begin
        item_v <= |new_mask;
        if (s_tlast) begin
          win  <= '0;
          fill <= 2'd0;
        end else begin
          win  <= {win[2:0], sample};
          fill <= (fill == FILL_FULL) ? FILL_FULL : fill + 2'd1;
        end
      end else if (done) begin
        item_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask   <= new_mask;
      seq[0] <= win[3];
      seq[1] <= win[2];
      seq[2] <= win[1];
      seq[3] <= win[0];
      seq[4] <= sample;
    end else if (take && item_v) begin
      mask <= remain;
    end
  end

endmodule

`default_nettype wire

>>> sv/dsfp_scale.sv
// Q16.16 scaling with round-half-up and saturation to 32 bits, three stages.
`default_nettype none

module dsfp_scale
  import dsfp_pkg::*;
#(
  parameter int SUM_W = 22
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [SCALE_W-1:0]      scale,
  output logic signed [OUT_W-1:0] result
);

  localparam int PW = SUM_W + SCALE_FRAC + 1;
  localparam int RW = (PW + 2 > OUT_W + 2) ? PW + 2 : OUT_W + 2;

  localparam logic signed [RW-1:0] SAT_HI = RW'(32'sh7FFF_FFFF);
  localparam logic signed [RW-1:0] SAT_LO = RW'(32'sh8000_0000);

  logic signed [SCALE_FRAC:0] hi_s;
  logic signed [SCALE_FRAC:0] lo_s;
  logic signed [PW-1:0]       prod_hi;
  logic signed [PW-1:0]       prod_lo;
  logic signed [PW-1:0]       lo_rnd;
  logic signed [PW-1:0]       lo_q;
  logic signed [RW-1:0]       r_next;
  logic signed [RW-1:0]       r;

  assign hi_s = {1'b0, scale[SCALE_W-1:SCALE_FRAC]};
  assign lo_s = {1'b0, scale[SCALE_FRAC-1:0]};

  // floor((sum*lo + half) / 2^16) + sum*hi
  assign lo_rnd = prod_lo + $signed(PW'(ROUND_HALF));
  assign lo_q   = lo_rnd >>> SCALE_FRAC;
  assign r_next = RW'(prod_hi) + RW'(lo_q);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_hi <= sum * hi_s;
      prod_lo <= sum * lo_s;
      r       <= r_next;
      if (r > SAT_HI) begin
        result <= OUT_W'(SAT_HI);
      end else if (r < SAT_LO) begin
        result <= OUT_W'(SAT_LO);
      end else begin
        result <= OUT_W'(r);
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_derivative_stencils_five_point.sv
// Self-checking testbench for the five-point derivative block: framed samples in, results out.
`timescale 1ns / 1ps

module tb_derivative_stencils_five_point;
  import dsfp_pkg::*;

  localparam int SAMPLE_W  = 16;
  localparam int DRAIN_CYC = 8;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_word_t;

  typedef struct {
    logic [OUT_W-1:0] d1;
    logic [OUT_W-1:0] d2;
    logic             last;
  } deriv_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [2*OUT_W-1:0]     m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0]     cfg_data = '0;

  sample_word_t  pending[$];
  deriv_word_t   deriv_due[$];
  longint        win[4];
  int            fill = 0;
  logic [31:0]   first_k = SCALE_RESET;
  logic [31:0]   second_k = SCALE_RESET;
  int            err_cnt = 0;
  int            words_in = 0;
  int            hold_at = 0;
  bit            took_word = 1'b0;
  bit            idle_on = 1'b1;
  bit            rx_hold = 1'b0;

  derivative_stencils_five_point #(.SAMPLE_BITS(SAMPLE_W)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // floor((sum * k + 2^15) / 2^16), clamped to int32
  function automatic logic [31:0] scaled_sat(longint sum, logic [31:0] k);
    longint prod;
    prod = (sum * longint'({32'd0, k}) + 64'sd32768) >>> SCALE_FRAC;
    if (prod > 64'sd2147483647) prod = 64'sd2147483647;
    if (prod < -64'sd2147483648) prod = -64'sd2147483648;
    return prod[31:0];
  endfunction

  task automatic push_deriv(longint a, longint b, longint c, longint d, longint e,
                            logic last);
    deriv_word_t w;
    w.d1 = scaled_sat(a - 8 * b + 8 * d - e, first_k);
    w.d2 = scaled_sat(-a + 16 * b - 30 * c + 16 * d - e, second_k);
    w.last = last;
    deriv_due = {deriv_due, w};
  endtask

  // win[0] newest
  task automatic predict_derivs(logic [SAMPLE_W-1:0] raw, logic last);
    longint s;
    s = $signed(raw);
    if (fill >= 2) push_deriv(win[3], win[2], win[1], win[0], s, 1'b0);
    if (last) begin
      if (fill >= 1) push_deriv(win[2], win[1], win[0], s, 0, 1'b0);
      push_deriv(win[1], win[0], s, 0, 0, 1'b1);
      foreach (win[i]) win[i] = 0;
      fill = 0;
    end else begin
      win[3] = win[2];
      win[2] = win[1];
      win[1] = win[0];
      win[0] = s;
      if (fill < 2) fill++;
    end
  endtask

  // sender
  always @(negedge clk) begin
    sample_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took_word) begin
      if (pending.size() > 0 && !(idle_on && $urandom_range(99) < 25)) begin
        w = pending.pop_front();
        s_tdata  <= w.sample;
        s_tlast  <= w.last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst || rx_hold) m_tready <= 1'b0;
    else m_tready <= !(idle_on && $urandom_range(99) < 25);
  end

  // long receiver hold-off while the sender keeps going
  initial begin
    while (hold_at == 0 || words_in < hold_at) @(posedge clk);
    rx_hold = 1'b1;
    repeat (80) @(posedge clk);
    rx_hold = 1'b0;
  end

  // monitor: predict on accepted samples, check accepted results
  always @(posedge clk) begin
    deriv_word_t want;
    took_word <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_derivs(s_tdata, s_tlast);
        words_in <= words_in + 1;
      end
      if (m_tvalid && m_tready) begin
        if (deriv_due.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want = deriv_due.pop_front();
          if (m_tdata[OUT_W-1:0] !== want.d1)
            flag_mismatch($sformatf("first_deriv %h, want %h", m_tdata[OUT_W-1:0], want.d1));
          if (m_tdata[2*OUT_W-1:OUT_W] !== want.d2)
            flag_mismatch($sformatf("second_deriv %h, want %h",
                                    m_tdata[2*OUT_W-1:OUT_W], want.d2));
          if (m_tlast !== want.last)
            flag_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
        end
      end
    end
  end

  task automatic write_scale(cfg_reg_t which, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (which)
      REG_FIRST_SCALE:  first_k = val;
      REG_SECOND_SCALE: second_k = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_word(logic [SAMPLE_W-1:0] sample, logic last);
    sample_word_t w;
    w.sample = sample;
    w.last = last;
    pending = {pending, w};
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1:       return 16'($urandom_range(16)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  // short frames, full-scale swings, zeros
  task automatic queue_extremes();
    push_word(16'h7FFF, 1'b1);
    push_word(16'h8000, 1'b1);
    push_word(16'h7FFF, 1'b0);
    push_word(16'h8000, 1'b1);
    push_word(16'd1, 1'b0);
    push_word(16'd2, 1'b0);
    push_word(16'd3, 1'b1);
    for (int i = 0; i < 6; i++) push_word(i[0] ? 16'h8000 : 16'h7FFF, i == 5);
    for (int i = 0; i < 4; i++) push_word(16'h0000, i == 3);
  endtask

  task automatic queue_frames(int n_items);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) push_word(rand_sample(), i == len - 1);
      cnt += len;
    end
  endtask

  task automatic wait_drained();
    while (pending.size() > 0 || s_tvalid || deriv_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_extremes();
    wait_drained();

    write_scale(REG_FIRST_SCALE, 32'hFFFF_FFFF);
    write_scale(REG_SECOND_SCALE, 32'h0000_0000);
    queue_extremes();
    queue_frames(15);
    wait_drained();

    write_scale(REG_FIRST_SCALE, 32'h0000_0000);
    write_scale(REG_SECOND_SCALE, 32'hFFFF_FFFF);
    queue_extremes();
    queue_frames(15);
    wait_drained();

    idle_on = 1'b0;
    write_scale(REG_FIRST_SCALE, 32'h0001_0000);
    write_scale(REG_SECOND_SCALE, $urandom());
    queue_frames(30);
    wait_drained();

    idle_on = 1'b1;
    write_scale(REG_FIRST_SCALE, $urandom_range(32'h0004_0000));
    write_scale(REG_SECOND_SCALE, $urandom());
    hold_at = words_in + 15;
    queue_frames(40);
    wait_drained();

    if (err_cnt == 0) $display("tb_derivative_stencils_five_point OK");
    else $display("tb_derivative_stencils_five_point NOT OK");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_derivative_stencils_five_point NOT OK");
    $finish;
  end

endmodule
